@@ hw/rtl/gjmi_pkg.sv @@
package gjmi_pkg;
   localparam int MAX_DIM_DEF   = 8;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [3:0] SIZE_RESET = 4'd3;
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_PIV_RD,
      ST_PIV_WT,
      ST_RECIP,
      ST_SCALE,
      ST_G_RD,
      ST_G_WT,
      ST_ELIM,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_MSUB
   } mac_op_type;

   typedef struct packed {
      logic       sat;
      logic [31:0] value;
   } mac_res_type;
endpackage

@@ hw/rtl/gjmi_mac.sv @@
module gjmi_mac #(
   parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     go,
   input  gjmi_pkg::mac_op_type     op,
   input  logic signed [31:0]       a,
   input  logic signed [31:0]       b,
   input  logic signed [31:0]       acc,
   output gjmi_pkg::mac_res_type    res
);
   import gjmi_pkg::*;

   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] acc_ff;
   mac_op_type         op_ff;
   logic               go_ff;
   logic [63:0]        mag;
   logic [63:0]        rnd;
   logic signed [64:0] q;
   logic               qsat;
   logic signed [31:0] qv;
   logic signed [33:0] diff;

   assign prod_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc;
      op_ff   <= op;
      go_ff   <= go;
   end

   always_comb begin
      mag  = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      rnd  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      q    = prod_ff[63] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
      qsat = 1'b0;
      qv   = q[31:0];
      if (q > 65'sd2147483647) begin
         qsat = 1'b1;
         qv   = SAT_MAX;
      end else if (q < -65'sd2147483648) begin
         qsat = 1'b1;
         qv   = SAT_MIN;
      end
      res.sat   = qsat;
      res.value = qv;
      diff = 34'(acc_ff) - 34'(qv);
      if (op_ff == OP_MSUB) begin
         if (diff > 34'sd2147483647) begin
            res.sat   = 1'b1;
            res.value = SAT_MAX;
         end else if (diff < -34'sd2147483648) begin
            res.sat   = 1'b1;
            res.value = SAT_MIN;
         end else begin
            res.value = diff[31:0];
         end
      end
      if (!go_ff) res.sat = 1'b0;
   end
endmodule

@@ hw/rtl/gjmi_recip.sv @@
module gjmi_recip #(
   parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [31:0]    pivot,
   output logic                  done,
   output gjmi_pkg::mac_res_type res
);
   import gjmi_pkg::*;

   localparam int NB = 2 * FRAC_BITS + 2;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] num_ff, num_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [32:0]   rem_ff, rem_in;
   logic [32:0]   div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic [33:0]   trial;
   logic [32:0]   pm;
   logic signed [NB:0] sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      pm      = pivot[31] ? (33'd0 - 33'(pivot)) : 33'(pivot);
      trial   = {rem_ff, num_ff[NB-1]} - {1'b0, div_ff};
      if (start) begin
         neg_in  = pivot[31];
         div_in  = pm;
         num_in  = (NB'(1) << (2 * FRAC_BITS)) + NB'(pm >> 1);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CW'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[NB-1]};
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      res.sat   = 1'b0;
      res.value = sq[31:0];
      if (sq > (NB+1)'(64'sd2147483647)) begin
         res.sat   = 1'b1;
         res.value = SAT_MAX;
      end else if (sq < -(NB+1)'(64'sd2147483648)) begin
         res.sat   = 1'b1;
         res.value = SAT_MIN;
      end
   end

   assign done = done_ff;
endmodule

@@ hw/rtl/gauss_jordan_matrix_inverse.sv @@
// Gauss-Jordan matrix inverter, signed fixed point (Q16.16 by default).
// Input: pulse start with req_element while busy is low; elements arrive
// row-major, n*n of them, n from the matrix_size register (0 acts as 1,
// above MAX_DIM acts as MAX_DIM). A partial load yields nothing.
// Config: APB port, matrix_size at address 0; a write restarts the load.
// After the last element the block is busy while it inverts: it sets up
// the identity, then per column reads the pivot, forms a bit-serial
// reciprocal and makes n*n element updates on the shared multiply-subtract
// unit, each as read, multiply, write work, write inverse; it fetches the
// factor of each other row and skips the pivot row. A zero pivot ends
// elimination early.
// It then emits n*n items on rsp_valid, one per cycle, with valid and last
// delayed through rv_ff and rv_d_ff to match the registered read data;
// rsp_last marks the final one; busy drops on the cycle of the final item.
// rsp_singular marks a zero pivot (elements then zero); rsp_overflow marks
// any saturation. The receiver cannot stall; results go out unconditionally.
// Reset sets the size to 3 and drops any partial load. Memory contents
// are not cleared.
module gauss_jordan_matrix_inverse #(
   parameter int MAX_DIM   = gjmi_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_element,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_inverse_element,
   output logic               rsp_last,
   output logic               rsp_singular,
   output logic               rsp_overflow,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import gjmi_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int IW = $clog2(MAX_DIM);
   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(CELLS);
   localparam int LW = $clog2(CELLS + 1);

   logic signed [31:0] work_mem [CELLS];
   logic signed [31:0] inv_mem  [CELLS];

   state_type     st_ff, st_in;
   logic [3:0]    size_ff, size_in;
   logic [LW-1:0] load_ff, load_in;
   logic [IW-1:0] col_ff, col_in, row_ff, row_in, c_ff, c_in;
   logic [1:0]    ph_ff, ph_in;
   logic          sing_ff, sing_in, ovf_ff, ovf_in;
   logic signed [31:0] f_ff, f_in, g_ff, g_in;
   logic signed [31:0] wrd_ff, ird_ff, wpv_ff, ipv_ff;
   logic [LW-1:0] k_ff, k_in;
   logic          rv_ff, rv_in, rl_ff, rl_in;
   logic signed [31:0] re_ff;

   logic [DW-1:0] n;
   logic [LW-1:0] cells;
   logic          cfg_wr;

   logic          w_we, i_we;
   logic [AW-1:0] w_wa, i_wa, w_ra, i_ra, w_pa, i_pa;
   logic signed [31:0] w_wd, i_wd;

   logic               mgo;
   mac_op_type         mop;
   logic signed [31:0] ma, mb, macc;
   mac_res_type        mres;
   logic               rstart, rdone;
   mac_res_type        rres;

   logic [AW-1:0] out_a;

   function automatic logic [AW-1:0] addr(input logic [IW-1:0] r,
                                          input logic [IW-1:0] c,
                                          input logic [DW-1:0] nn);
      logic [2*DW-1:0] t;
      t = (2*DW)'(r) * (2*DW)'(nn) + (2*DW)'(c);
      return t[AW-1:0];
   endfunction

   always_comb begin
      if (size_ff == 4'd0) n = DW'(1);
      else if (32'(size_ff) > MAX_DIM) n = DW'(MAX_DIM);
      else n = DW'(size_ff);
   end
   assign cells = LW'(n) * LW'(n);

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {28'd0, size_ff} : 32'd0;

   gjmi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock), .go(mgo), .op(mop), .a(ma), .b(mb), .acc(macc), .res(mres)
   );

   gjmi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock(clock), .reset(reset), .start(rstart), .pivot(wpv_ff),
      .done(rdone), .res(rres)
   );

   always_ff @(posedge clock) begin
      if (w_we) work_mem[w_wa] <= w_wd;
      if (i_we) inv_mem[i_wa] <= i_wd;
      wrd_ff <= work_mem[w_ra];
      ird_ff <= inv_mem[i_ra];
      wpv_ff <= work_mem[w_pa];
      ipv_ff <= inv_mem[i_pa];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_LOAD;
         size_ff <= SIZE_RESET;
         load_ff <= '0;
         sing_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         size_ff <= size_in;
         load_ff <= load_in;
         sing_ff <= sing_in;
         ovf_ff  <= ovf_in;
         rv_ff   <= rv_in;
      end
      col_ff <= col_in;
      row_ff <= row_in;
      c_ff   <= c_in;
      ph_ff  <= ph_in;
      f_ff   <= f_in;
      g_ff   <= g_in;
      k_ff   <= k_in;
      rl_ff  <= rl_in;
      re_ff  <= sing_ff ? 32'sd0 : ird_ff;
   end

   assign out_a = k_ff[AW-1:0];

   always_comb begin
      st_in = st_ff;  size_in = size_ff; load_in = load_ff;
      sing_in = sing_ff; ovf_in = ovf_ff;
      col_in = col_ff; row_in = row_ff; c_in = c_ff; ph_in = ph_ff;
      f_in = f_ff; g_in = g_ff; k_in = k_ff;
      rv_in = 1'b0; rl_in = 1'b0;
      w_we = 1'b0; i_we = 1'b0;
      w_wa = '0; i_wa = '0; w_wd = req_element; i_wd = '0;
      w_ra = addr(row_ff, c_ff, n); i_ra = w_ra;
      w_pa = addr(col_ff, c_ff, n); i_pa = w_pa;
      mgo = 1'b0; mop = OP_MUL; ma = wrd_ff; mb = f_ff; macc = wrd_ff;
      rstart = 1'b0;
      busy = (st_ff != ST_LOAD);

      if (cfg_wr && csr_paddr == 1'b0) begin
         size_in = csr_pwdata[3:0];
         load_in = '0;
      end

      case (st_ff)
         ST_LOAD: begin
            if (start && !(cfg_wr && csr_paddr == 1'b0)) begin
               w_we = 1'b1;
               w_wa = load_ff[AW-1:0];
               if (load_ff + 1'b1 >= cells) begin
                  load_in = '0;
                  st_in = ST_INIT;
                  sing_in = 1'b0; ovf_in = 1'b0;
                  row_in = '0; c_in = '0;
               end else begin
                  load_in = load_ff + 1'b1;
               end
            end
         end
         ST_INIT: begin
            i_we = 1'b1;
            i_wa = addr(row_ff, c_ff, n);
            i_wd = (row_ff == c_ff) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            if (DW'(c_ff) + 1'b1 == n) begin
               c_in = '0;
               if (DW'(row_ff) + 1'b1 == n) begin
                  col_in = '0; st_in = ST_PIV_RD;
               end else row_in = row_ff + 1'b1;
            end else c_in = c_ff + 1'b1;
         end
         ST_PIV_RD: begin
            c_in = col_ff;
            w_pa = addr(col_ff, col_ff, n);
            st_in = ST_PIV_WT;
         end
         ST_PIV_WT: begin
            if (wpv_ff == 32'sd0) begin
               sing_in = 1'b1;
               k_in = '0; st_in = ST_EMIT;
            end else begin
               rstart = 1'b1;
               st_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            if (rdone) begin
               f_in = rres.value;
               if (rres.sat) ovf_in = 1'b1;
               row_in = col_ff; c_in = '0; ph_in = '0;
               st_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // ph 0: read row col at c; 1: mul work; 2: write work, mul inv; 3: write inv
            w_ra = addr(col_ff, c_ff, n); i_ra = w_ra;
            mb = f_ff;
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  mgo = 1'b1; mop = OP_MUL; ma = wrd_ff; ph_in = 2'd2;
               end
               2'd2: begin
                  w_we = 1'b1; w_wa = w_ra; w_wd = mres.value;
                  if (mres.sat) ovf_in = 1'b1;
                  mgo = 1'b1; mop = OP_MUL; ma = ird_ff; ph_in = 2'd3;
               end
               default: begin
                  i_we = 1'b1; i_wa = i_ra; i_wd = mres.value;
                  if (mres.sat) ovf_in = 1'b1;
                  ph_in = 2'd0;
                  if (DW'(c_ff) + 1'b1 == n) begin
                     c_in = '0; row_in = '0;
                     st_in = (col_ff == '0) ? ((n == DW'(1)) ? ST_G_RD : ST_G_RD)
                                            : ST_G_RD;
                  end else c_in = c_ff + 1'b1;
               end
            endcase
         end
         ST_G_RD: begin
            if (row_ff == col_ff) begin
               if (DW'(row_ff) + 1'b1 == n) begin
                  if (DW'(col_ff) + 1'b1 == n) begin
                     k_in = '0; st_in = ST_EMIT;
                  end else begin
                     col_in = col_ff + 1'b1; st_in = ST_PIV_RD;
                  end
               end else row_in = row_ff + 1'b1;
            end else begin
               w_ra = addr(row_ff, col_ff, n);
               st_in = ST_G_WT;
            end
         end
         ST_G_WT: begin
            g_in = wrd_ff; c_in = '0; ph_in = '0;
            st_in = ST_ELIM;
         end
         ST_ELIM: begin
            w_ra = addr(row_ff, c_ff, n); i_ra = w_ra;
            w_pa = addr(col_ff, c_ff, n); i_pa = w_pa;
            ma = g_ff;
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  mgo = 1'b1; mop = OP_MSUB; mb = wpv_ff; macc = wrd_ff;
                  ph_in = 2'd2;
               end
               2'd2: begin
                  w_we = 1'b1; w_wa = w_ra; w_wd = mres.value;
                  if (mres.sat) ovf_in = 1'b1;
                  mgo = 1'b1; mop = OP_MSUB; mb = ipv_ff; macc = ird_ff;
                  ph_in = 2'd3;
               end
               default: begin
                  i_we = 1'b1; i_wa = i_ra; i_wd = mres.value;
                  if (mres.sat) ovf_in = 1'b1;
                  ph_in = 2'd0;
                  if (DW'(c_ff) + 1'b1 == n) begin
                     c_in = '0;
                     if (DW'(row_ff) + 1'b1 == n) begin
                        if (DW'(col_ff) + 1'b1 == n) begin
                           k_in = '0; st_in = ST_EMIT;
                        end else begin
                           col_in = col_ff + 1'b1; st_in = ST_PIV_RD;
                        end
                     end else begin
                        row_in = row_ff + 1'b1; st_in = ST_G_RD;
                     end
                  end else c_in = c_ff + 1'b1;
               end
            endcase
         end
         ST_EMIT: begin
            i_ra = out_a;
            if (k_ff < cells) begin
               k_in = k_ff + 1'b1;
               rv_in = 1'b1;
               rl_in = (k_ff + 1'b1 == cells);
            end else begin
               st_in = ST_LOAD;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   logic rv_d_ff, rl_d_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_d_ff <= 1'b0;
      else rv_d_ff <= rv_ff;
      rl_d_ff <= rl_ff;
   end

   // read data is registered behind the address; valid is delayed to match re_ff
   assign rsp_valid           = rv_d_ff;
   assign rsp_last            = rl_d_ff;
   assign rsp_inverse_element = re_ff;
   assign rsp_singular        = sing_ff;
   assign rsp_overflow        = ovf_ff;
endmodule

@@ hw/rtl/gjmi_check.sv @@
module gjmi_check (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last,
   input logic rsp_singular,
   input logic signed [31:0] rsp_inverse_element
);
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without valid");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy) else $error("result while idle");
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid) else $error("gap inside inverse");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_inverse_element == 32'sd0))
      else $error("singular with nonzero element");
   a_last_one: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_last) else $error("double last");
endmodule

bind gauss_jordan_matrix_inverse gjmi_check u_check (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last(rsp_last), .rsp_singular(rsp_singular),
   .rsp_inverse_element(rsp_inverse_element)
);
